>>> sv/srtf_pkg.sv
// ----------------------------------------------------------------------------
// srtf_pkg - shared types and codes of the SRTF scheduler
// Operation and register codes, the controller state type, the scan token
// and the write request that the controller hands to one slot cell.
// ----------------------------------------------------------------------------
`default_nettype none

package srtf_pkg;

    // input operation codes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // configuration register indexes (paddr[2])
    localparam logic REG_PROCESS_COUNT = 1'b0;
    localparam logic REG_QUANTUM       = 1'b1;

    localparam int unsigned TIME_W = 32;
    localparam int unsigned VAL_W  = 16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    // best candidate seen so far while the scan moves down the row
    typedef struct packed {
        logic             valid;
        logic [VAL_W-1:0] rem;
    } t_token;

    // write request to one slot cell
    typedef struct packed {
        logic             load;     // new process: arrival, burst, clear done
        logic             update;   // after a run: new remainder and done mark
        logic [VAL_W-1:0] arrival;
        logic [VAL_W-1:0] rem;
        logic             done;
    } t_slot_wr;

endpackage

`default_nettype wire

>>> sv/shortest_remaining_time_scheduler_core.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_core - preemptive SRTF scheduler
// A row of slot cells scanned by a token for the least remaining time,
// a small controller that runs the chosen slot one quantum and keeps time.
// ----------------------------------------------------------------------------
//
//   channel  | handshake              | payload
//   ---------+------------------------+--------------------------------------
//   request  | start / busy           | i_operation, i_slot, i_arrival_time,
//            |                        | i_burst_time
//   result   | o_result_valid (pulse) | o_chosen_slot, o_idle, o_completed,
//            |                        | o_time_now
//   config   | APB psel/penable/...   | paddr 0: process_count, 4: quantum
//
// A load request writes its slot straight from the request and busy stays
// low. A tick request walks the scan token down the row one cell per cycle,
// then the update state applies the run and the result strobes for one
// cycle as busy drops, so the next request may start then.
// Reset is synchronous; all slots come up done (unusable until loaded),
// time zero, process_count 0, quantum 1. The result side cannot stall.
// ----------------------------------------------------------------------------
`default_nettype none

module shortest_remaining_time_scheduler_core #(
    parameter int unsigned MAX_PROCESSES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // request
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_operation,
    input  wire logic [3:0]  i_slot,
    input  wire logic [15:0] i_arrival_time,
    input  wire logic [15:0] i_burst_time,
    // result
    output logic             o_result_valid,
    output logic [3:0]       o_chosen_slot,
    output logic             o_idle,
    output logic             o_completed,
    output logic [31:0]      o_time_now,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int unsigned IW = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int unsigned CW = IW + 1;
    localparam int unsigned TW = srtf_pkg::TIME_W;
    localparam int unsigned VW = srtf_pkg::VAL_W;

    // controller
    srtf_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_cnt, n_cnt;
    logic [TW-1:0]    r_time, n_time;
    logic [4:0]       r_count;
    logic [VW-1:0]    r_quantum;
    logic             r_res_valid, n_res_valid;
    logic [3:0]       r_res_slot, n_res_slot;
    logic             r_res_idle, n_res_idle;
    logic             r_res_done, n_res_done;

    logic             accept;
    logic             cfg_write;
    logic [CW-1:0]    count_eff;
    logic [VW-1:0]    quantum_eff;
    logic             run_update;
    logic [VW-1:0]    run_rem;
    logic             run_done;
    logic [VW-1:0]    time_inc;
    logic [TW:0]      time_sum;

    // scan chain
    srtf_pkg::t_token   tok     [MAX_PROCESSES];
    logic [IW-1:0]      tok_idx [MAX_PROCESSES];
    srtf_pkg::t_slot_wr cell_wr [MAX_PROCESSES];
    srtf_pkg::t_token   tok_last;
    logic [IW-1:0]      idx_last;

    assign busy      = (r_state != srtf_pkg::ST_IDLE);
    assign accept    = start && !busy;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    assign tok_last = tok[MAX_PROCESSES-1];
    assign idx_last = tok_idx[MAX_PROCESSES-1];

    // clamp the count to the table and treat a zero quantum as one
    always_comb begin
        if (32'(r_count) > 32'(MAX_PROCESSES)) begin
            count_eff = CW'(MAX_PROCESSES);
        end else begin
            count_eff = CW'(r_count);
        end
        quantum_eff = (r_quantum == '0) ? VW'(1) : r_quantum;
    end

    // ------------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_quantum <= VW'(1);
        end else if (cfg_write) begin
            unique case (paddr[2])
                srtf_pkg::REG_PROCESS_COUNT: r_count   <= pwdata[4:0];
                srtf_pkg::REG_QUANTUM:       r_quantum <= pwdata[VW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            srtf_pkg::REG_PROCESS_COUNT: prdata = {27'b0, r_count};
            srtf_pkg::REG_QUANTUM:       prdata = {16'b0, r_quantum};
            default:                     prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // slot cells: the head gets an empty token, each cell hands on its best
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < MAX_PROCESSES; g++) begin : g_cell
        srtf_pkg::t_token tok_in;
        logic [IW-1:0]    idx_in;

        if (g == 0) begin : g_head
            assign tok_in = '0;
            assign idx_in = '0;
        end else begin : g_link
            assign tok_in = tok[g-1];
            assign idx_in = tok_idx[g-1];
        end

        // load a slot straight from the accepted request; write back the run
        always_comb begin
            cell_wr[g].load    = accept && (i_operation == srtf_pkg::OP_LOAD)
                              && (32'(i_slot) == 32'(g));
            cell_wr[g].update  = run_update && (idx_last == IW'(g));
            cell_wr[g].arrival = i_arrival_time;
            cell_wr[g].rem     = cell_wr[g].load ? i_burst_time : run_rem;
            cell_wr[g].done    = run_done;
        end

        srtf_cell #(
            .IW (IW),
            .CW (CW)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_idx     (IW'(g)),
            .i_count   (count_eff),
            .i_time    (r_time),
            .i_wr      (cell_wr[g]),
            .i_tok     (tok_in),
            .i_tok_idx (idx_in),
            .o_tok     (tok[g]),
            .o_tok_idx (tok_idx[g])
        );
    end

    // ------------------------------------------------------------------------
    // controller: idle -> scan (one cell per cycle) -> update -> idle
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= srtf_pkg::ST_IDLE;
            r_cnt       <= '0;
            r_time      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_time      <= n_time;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res_slot <= n_res_slot;
        r_res_idle <= n_res_idle;
        r_res_done <= n_res_done;
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_time      = r_time;
        n_res_valid = 1'b0;
        n_res_slot  = r_res_slot;
        n_res_idle  = r_res_idle;
        n_res_done  = r_res_done;
        run_update  = 1'b0;
        run_rem     = '0;
        run_done    = 1'b0;
        time_inc    = VW'(1);

        // choose the time step: idle one, finish by the remainder, or a quantum
        if (!tok_last.valid) begin
            time_inc = VW'(1);
        end else if (tok_last.rem <= quantum_eff) begin
            time_inc = tok_last.rem;
            run_done = 1'b1;
        end else begin
            time_inc = quantum_eff;
            run_rem  = tok_last.rem - quantum_eff;
        end
        time_sum = {1'b0, r_time} + (TW+1)'(time_inc);

        unique case (r_state)
            srtf_pkg::ST_IDLE: begin
                if (accept && (i_operation == srtf_pkg::OP_TICK)) begin
                    n_state = srtf_pkg::ST_SCAN;
                    n_cnt   = '0;
                end
            end
            srtf_pkg::ST_SCAN: begin
                // hold until the token has passed the last cell
                n_cnt = r_cnt + IW'(1);
                if (r_cnt == IW'(MAX_PROCESSES - 1)) begin
                    n_state = srtf_pkg::ST_UPDATE;
                end
            end
            srtf_pkg::ST_UPDATE: begin
                n_state     = srtf_pkg::ST_IDLE;
                n_res_valid = 1'b1;
                run_update  = tok_last.valid;
                // saturate the time at its maximum
                n_time      = time_sum[TW] ? '1 : time_sum[TW-1:0];
                n_res_idle  = !tok_last.valid;
                n_res_done  = tok_last.valid && run_done;
                n_res_slot  = tok_last.valid ? 4'(idx_last) : 4'b0;
            end
            default: begin
                n_state = srtf_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_result_valid = r_res_valid;
    assign o_chosen_slot  = r_res_slot;
    assign o_idle         = r_res_idle;
    assign o_completed    = r_res_done;
    assign o_time_now     = r_time;

`ifndef SYNTHESIS
    // a result strobe follows only the update cycle of a tick
    a_result_after_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(r_state == srtf_pkg::ST_UPDATE))
        else $error("result strobe without a preceding update cycle");

    // time never runs backward
    a_time_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_time >= $past(r_time)))
        else $error("current time decreased");

    // an idle step never reports a completion
    a_idle_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !(o_idle && o_completed))
        else $error("idle and completed reported together");

    // the scan always enters with the counter cleared
    a_scan_from_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srtf_pkg::ST_SCAN && $past(r_state) == srtf_pkg::ST_IDLE)
            |-> (r_cnt == '0))
        else $error("scan started with a stale counter");
`endif

endmodule

`default_nettype wire

>>> sv/srtf_cell.sv
// ----------------------------------------------------------------------------
// srtf_cell - one process slot of the scheduler row
// Holds arrival, remaining time and done mark of one slot and folds itself
// into the scan token handed on from the previous cell, once per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module srtf_cell #(
    parameter int unsigned IW = 4,
    parameter int unsigned CW = 5
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [IW-1:0]               i_idx,
    input  wire logic [CW-1:0]               i_count,
    input  wire logic [srtf_pkg::TIME_W-1:0] i_time,
    input  wire srtf_pkg::t_slot_wr          i_wr,
    input  wire srtf_pkg::t_token            i_tok,
    input  wire logic [IW-1:0]               i_tok_idx,
    output srtf_pkg::t_token                 o_tok,
    output logic [IW-1:0]                    o_tok_idx
);

    logic [srtf_pkg::VAL_W-1:0] r_arrival;
    logic [srtf_pkg::VAL_W-1:0] r_rem;
    logic                       r_done;
    srtf_pkg::t_token           r_tok;
    srtf_pkg::t_token           n_tok;
    logic [IW-1:0]              r_tok_idx;
    logic [IW-1:0]              n_tok_idx;
    logic                       eligible;
    logic                       take;

    assign eligible = !r_done
                   && ({{(srtf_pkg::TIME_W-srtf_pkg::VAL_W){1'b0}}, r_arrival} <= i_time)
                   && (CW'({1'b0, i_idx}) < i_count);

    // strict compare keeps the lower index on a tie
    assign take = eligible && (!i_tok.valid || (r_rem < i_tok.rem));

    always_comb begin
        if (take) begin
            n_tok.valid = 1'b1;
            n_tok.rem   = r_rem;
            n_tok_idx   = i_idx;
        end else begin
            n_tok       = i_tok;
            n_tok_idx   = i_tok_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_arrival <= '0;
            r_rem     <= '0;
            r_done    <= 1'b1;
            r_tok     <= '0;
        end else begin
            r_tok <= n_tok;
            if (i_wr.load) begin
                r_arrival <= i_wr.arrival;
                r_rem     <= i_wr.rem;
                r_done    <= 1'b0;
            end else if (i_wr.update) begin
                r_rem     <= i_wr.rem;
                r_done    <= i_wr.done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_tok_idx <= n_tok_idx;
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule

`default_nettype wire

>>> sim/shortest_remaining_time_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// shortest_remaining_time_scheduler_core_tb - self-checking bench for the SRTF core
// A driver feeds load and tick requests from a queue and idles in random
// bursts. A built-in scheduler predictor produces the expected result of
// each accepted tick, and a monitor compares every strobed result with it.
// The APB port reconfigures the core between phases.
// ----------------------------------------------------------------------------
module shortest_remaining_time_scheduler_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAXP   = 16;
    localparam int unsigned SETTLE = MAXP + 4;   // cycles for a load or tick to drain
    localparam int unsigned RANDOM_PHASES = 8;
    localparam int unsigned PHASE_REQS    = 212;

    typedef struct packed {
        logic        op;
        logic [3:0]  slot;
        logic [15:0] arrival;
        logic [15:0] burst;
    } t_sched_req;

    typedef struct packed {
        logic [3:0]  slot;
        logic        idle;
        logic        completed;
        logic [31:0] now;
    } t_tick_res;

    // DUT connections
    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_operation = srtf_pkg::OP_LOAD;
    logic [3:0]  i_slot = '0;
    logic [15:0] i_arrival_time = '0;
    logic [15:0] i_burst_time = '0;
    logic        o_result_valid;
    logic [3:0]  o_chosen_slot;
    logic        o_idle;
    logic        o_completed;
    logic [31:0] o_time_now;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // scheduler predictor state
    logic [15:0] slot_rem [MAXP];
    logic [15:0] slot_arrival [MAXP];
    logic        slot_done [MAXP];
    logic [31:0] sched_time;
    logic [4:0]  active_count;
    logic [15:0] run_quantum;

    t_sched_req  pending_reqs [$];
    t_tick_res   tick_expect_q [$];
    t_sched_req  req_cur;
    t_tick_res   tick_exp;
    int unsigned mismatch_count = 0;
    int unsigned reqs_queued = 0;
    bit          gaps_on = 1'b1;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;

    shortest_remaining_time_scheduler_core #(
        .MAX_PROCESSES(MAXP)
    ) u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_slot         (i_slot),
        .i_arrival_time (i_arrival_time),
        .i_burst_time   (i_burst_time),
        .o_result_valid (o_result_valid),
        .o_chosen_slot  (o_chosen_slot),
        .o_idle         (o_idle),
        .o_completed    (o_completed),
        .o_time_now     (o_time_now),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Write one process slot: arrival, full burst as remainder, clear done.
    function automatic void load_slot(input t_sched_req req);
        if (req.slot < MAXP) begin
            slot_arrival[req.slot] = req.arrival;
            slot_rem[req.slot]     = req.burst;
            slot_done[req.slot]    = 1'b0;
        end
    endfunction

    // Pick the eligible slot with least remainder (lowest index on a tie),
    // run it one quantum and advance the saturating clock.
    function automatic t_tick_res predict_tick();
        t_tick_res   res;
        int          pick;
        int unsigned lim;
        logic [15:0] best;
        logic [15:0] q;
        logic [32:0] sum;
        lim  = (active_count > MAXP) ? MAXP : active_count;
        q    = (run_quantum == 0) ? 16'd1 : run_quantum;
        pick = -1;
        best = '0;
        res  = '0;
        for (int i = 0; i < lim; i++) begin
            if (!slot_done[i] && {16'd0, slot_arrival[i]} <= sched_time &&
                (pick < 0 || slot_rem[i] < best)) begin
                pick = i;
                best = slot_rem[i];
            end
        end
        if (pick < 0) begin
            sum      = {1'b0, sched_time} + 33'd1;
            res.idle = 1'b1;
        end else if (best <= q) begin
            slot_done[pick] = 1'b1;
            slot_rem[pick]  = '0;
            sum             = {1'b0, sched_time} + {17'd0, best};
            res.completed   = 1'b1;
            res.slot        = pick[3:0];
        end else begin
            slot_rem[pick] = best - q;
            sum            = {1'b0, sched_time} + {17'd0, q};
            res.slot       = pick[3:0];
        end
        sched_time = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        res.now    = sched_time;
        return res;
    endfunction

    // Driver: present requests from the queue, hold while busy, idle in bursts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                if (req_cur.op == srtf_pkg::OP_TICK) begin
                    tick_expect_q.push_back(predict_tick());
                end else begin
                    load_slot(req_cur);
                end
            end
            // hold the current request while the core is busy
            if (!start || !busy) begin
                if (gaps_on && burst_left == 0) begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
                end
                if (gap_left != 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_reqs.size() != 0) begin
                    req_cur = pending_reqs.pop_front();
                    start          <= 1'b1;
                    i_operation    <= req_cur.op;
                    i_slot         <= req_cur.slot;
                    i_arrival_time <= req_cur.arrival;
                    i_burst_time   <= req_cur.burst;
                    if (burst_left != 0) burst_left--;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed result must match the oldest expected tick.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (tick_expect_q.size() == 0) begin
                $error("unexpected result: chosen_slot %0d idle %0d completed %0d time_now %0d",
                       o_chosen_slot, o_idle, o_completed, o_time_now);
                mismatch_count++;
            end else begin
                tick_exp = tick_expect_q.pop_front();
                if (o_chosen_slot !== tick_exp.slot) begin
                    $error("chosen_slot: expected %0d, actual %0d", tick_exp.slot, o_chosen_slot);
                    mismatch_count++;
                end
                if (o_idle !== tick_exp.idle) begin
                    $error("idle: expected %0d, actual %0d", tick_exp.idle, o_idle);
                    mismatch_count++;
                end
                if (o_completed !== tick_exp.completed) begin
                    $error("completed: expected %0d, actual %0d",
                           tick_exp.completed, o_completed);
                    mismatch_count++;
                end
                if (o_time_now !== tick_exp.now) begin
                    $error("time_now: expected %0d, actual %0d", tick_exp.now, o_time_now);
                    mismatch_count++;
                end
            end
        end
    end

    task automatic push_load(input logic [3:0] s, input logic [15:0] a, input logic [15:0] b);
        pending_reqs.push_back(t_sched_req'{srtf_pkg::OP_LOAD, s, a, b});
        reqs_queued++;
    endtask

    task automatic push_tick();
        pending_reqs.push_back(t_sched_req'{srtf_pkg::OP_TICK, 4'd0, 16'd0, 16'd0});
        reqs_queued++;
    endtask

    // Wait until every request is taken, every result is in, and the core settles.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_reqs.size() != 0 || start || tick_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic reg_sel, input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == srtf_pkg::REG_PROCESS_COUNT) active_count = value[4:0];
        else run_quantum = value[15:0];
    endtask

    // One workload: load a few slots around the current time, then run ticks.
    // Now and then add a stray tick, or a load with fully random fields.
    task automatic push_episode();
        int unsigned k;
        int unsigned n;
        int unsigned lim;
        int unsigned af;
        int unsigned qmax;
        logic [3:0]  s;
        logic [15:0] a;
        logic [15:0] b;
        logic [15:0] base;
        k    = $urandom_range(1, 5);
        lim  = (active_count > MAXP) ? MAXP : active_count;
        base = (sched_time > 32'h0000_FFFF) ? 16'hFFFF : sched_time[15:0];
        qmax = ((run_quantum == 0) ? 1 : run_quantum) * 3;
        if (qmax > 65535) qmax = 65535;
        for (int i = 0; i < k; i++) begin
            if (lim != 0 && $urandom_range(0, 9) != 0) s = 4'($urandom_range(0, lim - 1));
            else s = 4'($urandom_range(0, 15));
            case ($urandom_range(0, 5))
                0: a = 16'($urandom);
                1: a = '0;
                default: begin
                    af = base + $urandom_range(0, 40);
                    a  = (af > 65535) ? 16'hFFFF : af[15:0];
                end
            endcase
            case ($urandom_range(0, 9))
                0:       b = '0;
                1:       b = 16'hFFFF;
                2, 3:    b = 16'($urandom);
                4, 5, 6: b = 16'($urandom_range(0, qmax));
                default: b = 16'($urandom_range(1, 24));
            endcase
            push_load(s, a, b);
        end
        n = $urandom_range(1, 3 * k + 3);
        repeat (n) push_tick();
        if ($urandom_range(0, 7) == 0) begin
            if ($urandom_range(0, 1) == 0) push_tick();
            else push_load(4'($urandom), 16'($urandom), 16'($urandom));
        end
    endtask

    initial begin : stimulus
        int unsigned phase_mark;
        logic [4:0]  cnt_sel;
        logic [15:0] q_sel;

        for (int i = 0; i < MAXP; i++) begin
            slot_rem[i]     = '0;
            slot_arrival[i] = '0;
            slot_done[i]    = 1'b1;
        end
        sched_time   = '0;
        active_count = '0;
        run_quantum  = 16'd1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset configuration: no slot in use, every tick is idle
        push_tick();
        push_tick();
        push_load(4'd0, 16'd0, 16'd3);
        push_tick();
        wait_idle();

        // full table, zero quantum acts as one; zero burst and equal remainders
        cfg_write(srtf_pkg::REG_PROCESS_COUNT, 32'd16);
        cfg_write(srtf_pkg::REG_QUANTUM, 32'd0);
        push_load(4'd15, 16'hFFFF, 16'hFFFF);
        push_load(4'd3, 16'd0, 16'd0);
        push_load(4'd5, 16'd0, 16'd2);
        push_load(4'd6, 16'd0, 16'd2);
        repeat (7) push_tick();
        wait_idle();

        // count above the table size, largest quantum
        cfg_write(srtf_pkg::REG_PROCESS_COUNT, 32'd31);
        cfg_write(srtf_pkg::REG_QUANTUM, 32'd65535);
        push_load(4'd1, 16'd0, 16'hFFFF);
        push_load(4'd2, 16'd7, 16'h5555);
        repeat (3) push_tick();

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            wait_idle();
            case (p)
                0:       begin cnt_sel = 5'd16; q_sel = 16'd1; end
                1:       begin cnt_sel = 5'd4;  q_sel = 16'd3; end
                2:       begin cnt_sel = 5'($urandom_range(17, 31)); q_sel = 16'd20; end
                3:       begin cnt_sel = 5'd1;  q_sel = 16'd2; end
                4:       begin cnt_sel = 5'd16; q_sel = 16'($urandom_range(1, 65535)); end
                5:       begin cnt_sel = 5'd2;  q_sel = 16'd0; end
                6:       begin cnt_sel = 5'd9;  q_sel = 16'd7; end
                default: begin cnt_sel = 5'd16; q_sel = 16'd65535; end
            endcase
            // junk in the unused upper bits must be dropped by the core
            cfg_write(srtf_pkg::REG_PROCESS_COUNT, ($urandom & 32'hFFFF_FFE0) | cnt_sel);
            cfg_write(srtf_pkg::REG_QUANTUM, ($urandom & 32'hFFFF_0000) | q_sel);
            gaps_on    = (p % 3 != 1);
            phase_mark = reqs_queued;
            while (reqs_queued < phase_mark + PHASE_REQS) begin
                while (pending_reqs.size() > 1) @(negedge i_clk);
                // pause now and then until every result is back
                if ($urandom_range(0, 19) == 0) wait_idle();
                push_episode();
            end
        end

        push_load(4'd0, 16'd0, 16'd5);
        push_tick();
        push_tick();

        wait_idle();
        if (mismatch_count == 0 && tick_expect_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
